### hdl/skrm_pkg.sv
package skrm_pkg;

  // Field widths
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned PROFIT_W = 48;
  localparam int unsigned ITEM_P_W = 32;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned ENTRY_W  = WEIGHT_W + PROFIT_W;

  // Row storage
  localparam int unsigned MAX_ENTRIES_DEF = 4096;

  // Register file
  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_CAPACITY   = 1'b0;
  localparam logic [31:0] CAPACITY_RESET = 32'd33554432;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  localparam logic FUNC_ADD       = 1'b0;
  localparam logic FUNC_ROW_RESET = 1'b1;

  typedef struct packed {
    logic                func;
    logic [WEIGHT_W-1:0] item_weight;
    logic [ITEM_P_W-1:0] item_profit;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  pair_count;
    logic [PROFIT_W-1:0] best_profit;
    logic                overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic row_reset;
    logic sum_en;
    logic step_en;
    logic finish;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DEC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

### hdl/sparse_knapsack_row_merge.sv
// Sparse knapsack row merge.
// Keeps one row of a sparse 0/1 knapsack table as (weight, profit) pairs in
// two banks of RAM, ping-ponging between them on every add.
// Input channel (in_valid_i / in_stall_o / in_data_i): func 0 adds an item,
// func 1 sets the row back to the single pair (0,0).
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// item with the new pair count, the last pair's profit and a sticky overflow.
// A row reset goes from the idle state straight to the done state. An add
// runs S merge steps and a closing check, where S is at most twice the
// live pair count (up to 2 * MAX_ENTRIES). Each step costs a RAM read,
// a shift/saturate stage and a compare/write stage.
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register.
// If the receiver stalls, the finished result holds in place and the next
// item waits in its done state until the output register frees.
// Reset gives the row (0,0), capacity 33554432 and a clear overflow flag;
// no clearing pass is needed. capacity is written over APB at address 0.
module sparse_knapsack_row_merge import skrm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] capacity_q;
  logic        reg_sel;
  cmd_t        cmd;
  sts_t        sts;

  // Register write and read back
  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];
  assign prdata  = (reg_sel == REG_CAPACITY) ? capacity_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_CAPACITY)) begin
      capacity_q <= pwdata;
    end
  end

  skrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  skrm_dp #(.MaxEntries(MAX_ENTRIES)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .item_i    (in_data_i),
    .capacity_i(capacity_q),
    .out_data_o(out_data_o)
  );

endmodule

### hdl/skrm_ram.sv
module skrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hdl/skrm_ctrl.sv
module skrm_ctrl import skrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_func_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one item: a row reset goes straight to done; an add reads, sums and decides per merge step
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == FUNC_ROW_RESET) begin
            cmd_o.row_reset = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_DEC;
      end
      ST_DEC: begin
        if (sts_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.step_en = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/skrm_dp.sv
module skrm_dp import skrm_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  in_item_t            item_i,
  input  logic [WEIGHT_W-1:0] capacity_i,
  output out_item_t           out_data_o
);

  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned AW = $clog2(MaxEntries);
  localparam logic [CW-1:0] MaxCount = CW'(MaxEntries);

  // Item operands
  logic [WEIGHT_W-1:0] iw_q;
  logic [ITEM_P_W-1:0] ip_q;

  // Row control state
  logic [CW-1:0] j_q, k_q, dst_n_q, live_count_q;
  logic          live_bank_q, row_reset_q, ovf_q;
  logic [PROFIT_W-1:0] best_q;

  // Step operands
  logic [WEIGHT_W-1:0] ow_q;
  logic [PROFIT_W-1:0] op_q;
  logic [WEIGHT_W:0]   tw_q;
  logic [PROFIT_W-1:0] tp_q;
  logic                j_ok_q, k_ok_q;

  out_item_t out_q;

  // Banks
  logic               a_we, b_we, wr_en;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] a_rd_j, a_rd_k, b_rd_j, b_rd_k;
  logic [ENTRY_W-1:0] src_j, src_k;

  skrm_ram #(.Width(ENTRY_W), .Depth(MaxEntries)) u_bank_a (
    .clk_i    (clk_i),
    .we_i     (a_we),
    .waddr_i  (dst_n_q[AW-1:0]),
    .wdata_i  (wdata),
    .raddr_a_i(j_q[AW-1:0]),
    .raddr_b_i(k_q[AW-1:0]),
    .rdata_a_o(a_rd_j),
    .rdata_b_o(a_rd_k)
  );

  skrm_ram #(.Width(ENTRY_W), .Depth(MaxEntries)) u_bank_b (
    .clk_i    (clk_i),
    .we_i     (b_we),
    .waddr_i  (dst_n_q[AW-1:0]),
    .wdata_i  (wdata),
    .raddr_a_i(j_q[AW-1:0]),
    .raddr_b_i(k_q[AW-1:0]),
    .rdata_a_o(b_rd_j),
    .rdata_b_o(b_rd_k)
  );

  // Pick the live bank; a freshly reset row reads as the pair (0,0)
  assign src_j = row_reset_q ? '0 : (live_bank_q ? b_rd_j : a_rd_j);
  assign src_k = row_reset_q ? '0 : (live_bank_q ? b_rd_k : a_rd_k);

  // Shift the k pair by the item
  logic [WEIGHT_W:0]   tw_d;
  logic [PROFIT_W:0]   tp_sum;
  logic [PROFIT_W-1:0] tp_d;

  assign tw_d   = {1'b0, src_k[ENTRY_W-1 -: WEIGHT_W]} + {1'b0, iw_q};
  assign tp_sum = {1'b0, src_k[PROFIT_W-1:0]} + (PROFIT_W + 1)'(ip_q);
  assign tp_d   = tp_sum[PROFIT_W] ? PROFIT_MAX : tp_sum[PROFIT_W-1:0];

  // Decide which head advances and which pair is kept
  logic emit_old, emit_new, adv_j, adv_k;
  logic [WEIGHT_W:0] ow_ext;

  assign ow_ext = {1'b0, ow_q};

  always_comb begin
    emit_old = 1'b0;
    emit_new = 1'b0;
    adv_j    = 1'b0;
    adv_k    = 1'b0;
    priority if (j_ok_q && k_ok_q) begin
      priority if (ow_ext < tw_q) begin
        if (op_q < tp_q) begin
          emit_old = 1'b1;
          adv_j    = 1'b1;
        end else begin
          adv_k = 1'b1;
        end
      end else if (ow_ext > tw_q) begin
        if (op_q > tp_q) begin
          emit_new = 1'b1;
          adv_k    = 1'b1;
        end else begin
          adv_j = 1'b1;
        end
      end else begin
        if (op_q > tp_q) begin
          adv_k = 1'b1;
        end else begin
          adv_j = 1'b1;
        end
      end
    end else if (j_ok_q) begin
      emit_old = 1'b1;
      adv_j    = 1'b1;
    end else if (k_ok_q) begin
      emit_new = 1'b1;
      adv_k    = 1'b1;
    end else begin
      adv_j = 1'b0;
    end
  end

  logic emit, row_full;

  assign emit     = emit_old || emit_new;
  assign row_full = (dst_n_q == MaxCount);
  assign wr_en    = cmd_i.step_en && emit && !row_full;
  assign wdata    = emit_old ? {ow_q, op_q} : {tw_q[WEIGHT_W-1:0], tp_q};
  assign a_we     = wr_en && live_bank_q;
  assign b_we     = wr_en && !live_bank_q;

  assign sts_o.done = !j_ok_q && !k_ok_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q          <= '0;
      k_q          <= '0;
      dst_n_q      <= '0;
      live_count_q <= CW'(1);
      live_bank_q  <= 1'b0;
      row_reset_q  <= 1'b1;
      ovf_q        <= 1'b0;
      j_ok_q       <= 1'b0;
      k_ok_q       <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        j_q     <= '0;
        k_q     <= '0;
        dst_n_q <= '0;
      end
      if (cmd_i.row_reset) begin
        live_count_q <= CW'(1);
        live_bank_q  <= 1'b0;
        row_reset_q  <= 1'b1;
      end
      if (cmd_i.sum_en) begin
        j_ok_q <= (j_q < live_count_q);
        k_ok_q <= (k_q < live_count_q) && (tw_d <= {1'b0, capacity_i});
      end
      if (cmd_i.step_en) begin
        if (adv_j) begin
          j_q <= j_q + CW'(1);
        end
        if (adv_k) begin
          k_q <= k_q + CW'(1);
        end
        if (wr_en) begin
          dst_n_q <= dst_n_q + CW'(1);
        end
        if (emit && row_full) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        live_count_q <= dst_n_q;
        live_bank_q  <= !live_bank_q;
        row_reset_q  <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [CW+12:0] count_ext;

  assign count_ext = {13'b0, live_count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      iw_q   <= item_i.item_weight;
      ip_q   <= item_i.item_profit;
      best_q <= '0;
    end
    if (cmd_i.row_reset) begin
      best_q <= '0;
    end
    if (cmd_i.sum_en) begin
      ow_q <= src_j[ENTRY_W-1 -: WEIGHT_W];
      op_q <= src_j[PROFIT_W-1:0];
      tw_q <= tw_d;
      tp_q <= tp_d;
    end
    if (wr_en) begin
      best_q <= wdata[PROFIT_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_q.pair_count  <= count_ext[COUNT_W-1:0];
      out_q.best_profit <= best_q;
      out_q.overflow    <= ovf_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/skrm_checker.sv
module skrm_checker import skrm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;
  logic       ovf_seen_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track items in flight and the delivered overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      ovf_seen_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && out_data_o.overflow) begin
        ovf_seen_q <= 1'b1;
      end
    end
  end

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One item at a time: input closes right after an accept
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second item taken while one is in work");

  // No result without an item behind it
  a_no_extra_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without an accepted item");

  // Overflow never clears once reported
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovf_seen_q |-> out_data_o.overflow)
    else $error("overflow flag cleared");

endmodule

bind sparse_knapsack_row_merge skrm_checker u_skrm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import skrm_pkg::*;

  localparam int unsigned ROW_LIMIT = MAX_ENTRIES_DEF;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(REG_CAPACITY) << 2;
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = CAPACITY_ADDR + PADDR_W'(4);
  localparam int HOLD_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sparse_knapsack_row_merge #(.MAX_ENTRIES(ROW_LIMIT)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the row and its settings
  logic [WEIGHT_W-1:0] row_w[$];
  logic [PROFIT_W-1:0] row_p[$];
  logic [WEIGHT_W-1:0] next_w[$];
  logic [PROFIT_W-1:0] next_p[$];
  logic row_overflow = 1'b0;
  logic [31:0] capacity_model = CAPACITY_RESET;

  in_item_t pending_items[$];
  out_item_t expected_rows[$];
  int unsigned error_count = 0;
  int hold_requests = 0;

  function automatic logic [PROFIT_W-1:0] sat_profit(logic [PROFIT_W-1:0] a,
                                                     logic [ITEM_P_W-1:0] b);
    logic [PROFIT_W:0] sum;
    sum = {1'b0, a} + {{(PROFIT_W + 1 - ITEM_P_W){1'b0}}, b};
    return sum[PROFIT_W] ? PROFIT_MAX : sum[PROFIT_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W:0] shift_weight(logic [WEIGHT_W-1:0] a,
                                                    logic [WEIGHT_W-1:0] b);
    return {1'b0, a} + {1'b0, b};
  endfunction

  // Append a pair to the new row, or drop it and flag overflow when full
  task automatic keep_pair(input logic [WEIGHT_W-1:0] w, input logic [PROFIT_W-1:0] p);
    if (next_w.size() < ROW_LIMIT) begin
      next_w.insert(next_w.size(), w);
      next_p.insert(next_p.size(), p);
    end else begin
      row_overflow = 1'b1;
    end
  endtask

  // Apply one item to the shadow row and queue the row summary it yields
  task automatic merge_row(input in_item_t item);
    logic [WEIGHT_W:0] cap_ext;
    logic [WEIGHT_W:0] old_w;
    logic [WEIGHT_W:0] sh_w;
    logic [PROFIT_W-1:0] sh_p;
    out_item_t res;
    int cnt;
    int j;
    int k;
    cap_ext = {1'b0, capacity_model};
    if (item.func == FUNC_ROW_RESET) begin
      row_w = '{};
      row_p = '{};
      row_w.insert(0, '0);
      row_p.insert(0, '0);
    end else begin
      next_w = '{};
      next_p = '{};
      cnt = row_w.size();
      j = 0;
      k = 0;
      // Merge old and shifted heads, dropping the dominated one
      while (j < cnt && k < cnt && shift_weight(row_w[k], item.item_weight) <= cap_ext) begin
        old_w = {1'b0, row_w[j]};
        sh_w = shift_weight(row_w[k], item.item_weight);
        sh_p = sat_profit(row_p[k], item.item_profit);
        if (old_w < sh_w) begin
          if (row_p[j] < sh_p) begin
            keep_pair(row_w[j], row_p[j]);
            j++;
          end else begin
            k++;
          end
        end else if (old_w > sh_w) begin
          if (row_p[j] > sh_p) begin
            keep_pair(sh_w[WEIGHT_W-1:0], sh_p);
            k++;
          end else begin
            j++;
          end
        end else if (row_p[j] > sh_p) begin
          k++;
        end else begin
          j++;
        end
      end
      // Drain the old tail, then shifted pairs up to capacity
      while (j < cnt) begin
        keep_pair(row_w[j], row_p[j]);
        j++;
      end
      while (k < cnt && shift_weight(row_w[k], item.item_weight) <= cap_ext) begin
        sh_w = shift_weight(row_w[k], item.item_weight);
        keep_pair(sh_w[WEIGHT_W-1:0], sat_profit(row_p[k], item.item_profit));
        k++;
      end
      row_w = next_w;
      row_p = next_p;
    end
    res.pair_count = COUNT_W'(row_w.size());
    res.best_profit = (row_p.size() > 0) ? row_p[row_p.size() - 1] : '0;
    res.overflow = row_overflow;
    expected_rows.insert(expected_rows.size(), res);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Sender: offer queued items, hold while stalled, idle at random between items
  int gap_left = 0;
  int sent_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        merge_row(in_data);
        sent_count++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if ((sent_count / 16) % 4 == 3 || $urandom_range(0, 1) == 0) begin
          gap_left <= 0;
        end else begin
          gap_left <= idle_len();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result, stall at random, serve long hold-offs
  int stall_left = 0;
  int hold_left = 0;
  int hold_served = 0;
  int rows_checked = 0;
  out_item_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        rows_checked++;
        if (expected_rows.size() == 0) begin
          $error("unexpected result: pair_count %0d best_profit %0d overflow %0b",
                 out_data.pair_count, out_data.best_profit, out_data.overflow);
          error_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_data.pair_count !== want.pair_count) begin
            $error("pair_count: expected %0d, got %0d", want.pair_count, out_data.pair_count);
            error_count++;
          end
          if (out_data.best_profit !== want.best_profit) begin
            $error("best_profit: expected %0d, got %0d",
                   want.best_profit, out_data.best_profit);
            error_count++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ((rows_checked / 20) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // APB access: setup cycle, then access cycle
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == CAPACITY_ADDR) capacity_model = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_check_capacity();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAPACITY_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== capacity_model) begin
      $error("capacity: expected %0d, got %0d", capacity_model, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [31:0] value);
    cfg_write(CAPACITY_ADDR, value);
    cfg_check_capacity();
  endtask

  task automatic push_item(input logic func, input logic [31:0] w, input logic [31:0] p);
    in_item_t it;
    it.func = func;
    it.item_weight = w;
    it.item_profit = p;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Mostly small values so rows interact, plus extremes and full-range words
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(0, 63);
    if (r < 8) return $urandom_range(0, 4096);
    return $urandom;
  endfunction

  // Wait until every item went through and every result came back;
  // sample mid-cycle so the sender's updates at the edge are settled
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Random phase: reset-led add sequences with some noise items mixed in
  task automatic random_phase(input logic [31:0] cap, input int count, input bit pressure);
    int n;
    int added;
    set_capacity(cap);
    added = 0;
    while (added < count) begin
      push_item(FUNC_ROW_RESET, $urandom, $urandom);
      added++;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          push_item(1'($urandom_range(0, 1)), $urandom, $urandom);
        end else begin
          push_item(FUNC_ADD, pick_value(), pick_value());
        end
        added++;
      end
    end
    if (pressure) hold_requests++;
    wait_drained();
  endtask

  initial begin
    row_w.insert(0, '0);
    row_p.insert(0, '0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_check_capacity();

    // Equal weights, ties, dominance, wraparound and exact capacity
    push_item(FUNC_ADD, 32'd0, 32'd0);
    push_item(FUNC_ADD, 32'd3, 32'd7);
    push_item(FUNC_ADD, 32'd3, 32'd7);
    push_item(FUNC_ADD, 32'd2, 32'd1);
    push_item(FUNC_ADD, 32'd1, 32'd100);
    push_item(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(FUNC_ADD, CAPACITY_RESET, 32'd5);
    push_item(FUNC_ROW_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(FUNC_ADD, 32'd0, 32'hFFFF_FFFF);
    push_item(FUNC_ADD, 32'h8000_0000, 32'h8000_0000);
    push_item(FUNC_ROW_RESET, 32'd0, 32'd0);
    push_item(FUNC_ADD, 32'd10, 32'd1);
    push_item(FUNC_ADD, 32'd20, 32'd50);
    push_item(FUNC_ADD, 32'd5, 32'd2);
    wait_drained();

    // Widest capacity: a full-range weight still fits onto the empty pair
    set_capacity(32'hFFFF_FFFF);
    push_item(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(FUNC_ADD, 32'd1, 32'd1);
    wait_drained();

    // Zero capacity: old heavy pairs stay, only zero-weight shifts fit
    set_capacity(32'd0);
    push_item(FUNC_ADD, 32'd0, 32'd3);
    push_item(FUNC_ADD, 32'd1, 32'd1);
    push_item(FUNC_ROW_RESET, 32'd0, 32'd0);
    push_item(FUNC_ADD, 32'd0, 32'd0);
    wait_drained();

    // Small capacity; a write to an unmapped address must change nothing
    set_capacity(32'd12);
    cfg_write(UNUSED_ADDR, $urandom);
    cfg_check_capacity();
    push_item(FUNC_ROW_RESET, 32'd0, 32'd0);
    push_item(FUNC_ADD, 32'd5, 32'd5);
    push_item(FUNC_ADD, 32'd4, 32'd4);
    push_item(FUNC_ADD, 32'd3, 32'd3);
    push_item(FUNC_ADD, 32'd4, 32'd6);
    wait_drained();

    random_phase($urandom, 12, 1'b1);
    random_phase($urandom_range(0, 300), 12, 1'b0);
    random_phase(32'hFFFF_FFFF, 12, 1'b1);
    random_phase($urandom_range(64, 5000), 12, 1'b0);

    // Fill the row: powers of two give distinct sums, the last add overflows
    set_capacity(CAPACITY_RESET);
    push_item(FUNC_ROW_RESET, 32'd0, 32'd0);
    for (int i = 0; i <= 12; i++) begin
      push_item(FUNC_ADD, 32'd1 << i, 32'd1 << i);
    end
    push_item(FUNC_ROW_RESET, 32'd0, 32'd0);
    push_item(FUNC_ADD, 32'd1, 32'd1);
    wait_drained();

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hdl/skrm_pkg.sv
hdl/skrm_ram.sv
hdl/skrm_ctrl.sv
hdl/skrm_dp.sv
hdl/sparse_knapsack_row_merge.sv
hdl/skrm_checker.sv
bench/tb_top.sv
